[src/upd_pkg.sv]
// Shared types and constants for the URL percent decoder.
// Used by the decode stage, the result queue and the top level; no dependencies.
`default_nettype none
package upd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

   // Escape phase codes.
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PERCENT = 2'd1;
   localparam logic [1:0] PHASE_DIGIT   = 2'd2;

   localparam logic [ByteWidth-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [ByteWidth-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [ByteWidth-1:0] CHAR_SPACE   = 8'h20;

   // One decoded byte with its end-of-string flag.
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
   } upd_entry_type;

   // What one input byte produces: zero, one or two decoded bytes.
   typedef struct packed {
      logic [1:0]    count;
      upd_entry_type first;
      upd_entry_type second;
   } upd_result_type;

   function automatic logic is_escape_char(input logic [ByteWidth-1:0] c);
      return ((c >= 8'h30) && (c < 8'h40)) || ((c >= 8'h41) && (c < 8'h47));
   endfunction

   // Returns {valid, nibble}; valid is low for the non-hex escape chars.
   function automatic logic [4:0] hex_value(input logic [ByteWidth-1:0] c);
      logic [4:0] result;
      result = 5'd0;
      if ((c >= 8'h30) && (c < 8'h3A)) begin
         result = {1'b1, c[3:0]};
      end else if ((c >= 8'h41) && (c < 8'h47)) begin
         result = {1'b1, c[3:0] + 4'd9};
      end
      return result;
   endfunction

endpackage
`default_nettype wire

[src/upd_decode.sv]
// Decode stage: escape state registers and the single-pass byte decoder.
// Depends on upd_pkg.
`default_nettype none
module upd_decode
   import upd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [ByteWidth-1:0] in_data,
   input  wire logic                 in_last,
   output upd_result_type            result
);

   logic [1:0]           phase_ff, phase_in;
   logic [ByteWidth-1:0] held_ff, held_in;

   logic [4:0]           held_hex;
   logic [4:0]           cur_hex;
   logic [ByteWidth-1:0] escape_value;
   logic                 cur_escape;

   // Plain-path decode of the current byte, used in several phases.
   upd_entry_type        plain_entry;
   logic                 plain_emits;
   logic                 plain_opens;

   always_comb begin
      held_hex   = hex_value(held_ff);
      cur_hex    = hex_value(in_data);
      cur_escape = is_escape_char(in_data);
      if (!held_hex[4]) begin
         escape_value = '0;
      end else if (!cur_hex[4]) begin
         escape_value = {4'd0, held_hex[3:0]};
      end else begin
         escape_value = {held_hex[3:0], cur_hex[3:0]};
      end
   end

   always_comb begin
      plain_entry.last = in_last;
      plain_emits      = 1'b1;
      plain_opens      = 1'b0;
      if (in_data == CHAR_PERCENT) begin
         plain_entry.data = in_data;
         plain_emits      = in_last;
         plain_opens      = !in_last;
      end else if (in_data == CHAR_PLUS) begin
         plain_entry.data = CHAR_SPACE;
      end else begin
         plain_entry.data = in_data;
      end
   end

   always_comb begin
      result   = '0;
      phase_in = PHASE_IDLE;
      held_in  = held_ff;
      unique case (phase_ff)
         PHASE_PERCENT: begin
            if (cur_escape) begin
               if (in_last) begin
                  result.count  = 2'd1;
                  result.first  = '{data: in_data, last: 1'b1};
               end else begin
                  held_in  = in_data;
                  phase_in = PHASE_DIGIT;
               end
            end else begin
               result.count = {1'b0, plain_emits};
               result.first = plain_entry;
               phase_in     = plain_opens ? PHASE_PERCENT : PHASE_IDLE;
            end
         end
         PHASE_DIGIT: begin
            if (cur_escape) begin
               result.count = 2'd1;
               result.first = '{data: escape_value, last: in_last};
            end else begin
               // Bad second char: the held char goes out as itself first.
               result.count  = plain_emits ? 2'd2 : 2'd1;
               result.first  = '{data: held_ff, last: 1'b0};
               result.second = plain_entry;
               phase_in      = plain_opens ? PHASE_PERCENT : PHASE_IDLE;
            end
         end
         default: begin
            result.count = {1'b0, plain_emits};
            result.first = plain_entry;
            phase_in     = plain_opens ? PHASE_PERCENT : PHASE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("escape phase took an unused code");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last) |=> (phase_ff == PHASE_IDLE))
      else $error("escape state survived the end of a string");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last) |-> (result.count != 2'd0))
      else $error("final byte of a string produced no output");

endmodule
`default_nettype wire

[src/upd_out_queue.sv]
// Result queue: holds decoded bytes until the receiver takes them.
// Depends on upd_pkg.
`default_nettype none
module upd_out_queue
   import upd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire upd_result_type        result,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output upd_entry_type              out_entry
);

   upd_entry_type         mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            push_count;
   logic                  pop;

   assign push_count = push ? result.count : 2'd0;
   assign pop        = out_valid && out_ready;
   assign out_valid  = count_ff != '0;
   assign out_entry  = mem_ff[rd_ptr_ff];
   // Two free slots cover the worst case of one byte.
   assign room       = count_ff <= CountWidth'(QueueDepth - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push_count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      count_in  = count_ff + CountWidth'(push_count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push && (push_count != 2'd0)) begin
         mem_ff[wr_ptr_ff] <= result.first;
      end
      if (push && (push_count == 2'd2)) begin
         mem_ff[wr_ptr_ff + PtrWidth'(1)] <= result.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("result queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PtrWidth-1:0])
      else $error("result queue pointers disagree with count");

endmodule
`default_nettype wire

[src/url_percent_decoder_core.sv]
// URL percent decoder top level: input register, decode stage and result queue.
// Depends on upd_pkg, upd_decode and upd_out_queue.
//
// Usage:
//   The req_ channel carries the encoded string, one byte per beat, with
//   req_tlast on the final byte. The rsp_ channel returns decoded bytes, one
//   per beat, with rsp_tlast on the final decoded byte of each string.
//   A plus sign becomes a space, a percent sign with two escape characters
//   becomes one byte, and a broken escape drops its percent sign.
//   A byte is captured in the input register, decoded straight into the result
//   queue once the queue has room, and is then presented on rsp_ from the queue.
//   Throughput: one byte per cycle while the queue has room. A byte that yields
//   two results (a bad second escape character) needs two rsp_ beats, so the
//   output port, one beat per cycle, sets the sustained rate in that case.
//   Stalls: the four-entry result queue decouples the sides; the input keeps
//   flowing while the queue has two free entries, and req_tready falls only
//   once results back up behind a stalled receiver.
//   Reset: synchronous and active high; it empties the input register and the
//   queue and returns the escape state to idle.
`default_nettype none
module url_percent_decoder_core
   import upd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  wire logic                 req_tlast,   // in_last
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ByteWidth-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tlast    // out_last
);

   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_data_ff;
   logic                 in_last_ff;
   logic                 room;
   logic                 advance;
   upd_result_type       result;
   upd_entry_type        out_entry;

   // The held byte moves into the decoder whenever the queue can take its
   // worst case; the input register refills in the same cycle.
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   upd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_data (in_data_ff),
      .in_last (in_last_ff),
      .result  (result)
   );

   upd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .result    (result),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry)
   );

   assign rsp_tdata = out_entry.data;
   assign rsp_tlast = out_entry.last;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input register lost a byte while the queue was full");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input refused with an empty input register");

   a_advance_needs_room: assert property (@(posedge clock) disable iff (reset)
      advance |-> room)
      else $error("decode advanced without queue room");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder_core: a table of directed strings, then
// random strings, with every decoded beat compared against the table or a behavioral decoder.
// Depends on upd_pkg and the url_percent_decoder_core RTL.
module tb_top
   import upd_pkg::*;
();

   localparam int RandomItems = 1350;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 8;

   // Receiver pacing modes.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_OFTEN,
      READY_SELDOM
   } ready_mode_type;

   // One row of stimulus. When typed is set, want holds the decoded beats written out by
   // hand; otherwise the behavioral decoder supplies them.
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
      logic                 typed;
      upd_result_type       want;
   } stim_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ByteWidth-1:0] rsp_tdata;
   logic                 rsp_tlast;

   stim_row_type         directed_rows[$];
   stim_row_type         cur_row = '0;
   logic [ByteWidth-1:0] text_q[$];
   upd_entry_type        decoded_q[$];

   // State of the behavioral decoder.
   logic [1:0]           esc_phase = PHASE_IDLE;
   logic [ByteWidth-1:0] esc_lead  = '0;

   int             bytes_taken = 0;
   int             idle_cycles = 0;
   int             error_count = 0;
   int             burst_left  = 0;
   int             mode_left   = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;

   url_percent_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("tb_top: mismatch: %s", msg);
      error_count++;
   endtask

   // Escape characters are the whole 0x3? column plus uppercase A..F.
   function automatic logic escape_like(input logic [ByteWidth-1:0] c);
      return (c[7:4] == 4'h3) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   // Hex digit value, or -1 for the escape characters that are not hex digits.
   function automatic int digit_value(input logic [ByteWidth-1:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic logic [ByteWidth-1:0] hex_char(input int d);
      return (d < 10) ? 8'(8'h30 + d) : 8'(8'h41 + d - 10);
   endfunction

   function automatic void expect_beat(input logic [ByteWidth-1:0] b, input logic l);
      upd_entry_type e;
      e.data = b;
      e.last = l;
      decoded_q.insert(decoded_q.size(), e);
   endfunction

   // Handling of a byte while no escape is open.
   function automatic void decode_plain(input logic [ByteWidth-1:0] c, input logic l);
      if (c == CHAR_PERCENT) begin
         // A percent sign at the very end has nothing to escape and stands for itself.
         if (l) expect_beat(c, 1'b1);
         else esc_phase = PHASE_PERCENT;
      end else if (c == CHAR_PLUS) begin
         expect_beat(CHAR_SPACE, l);
      end else begin
         expect_beat(c, l);
      end
   endfunction

   // Advances the behavioral decoder by one input byte and queues the beats it yields.
   function automatic void decode_byte(input logic [ByteWidth-1:0] c, input logic l);
      logic [1:0] phase;
      int         hi, lo;
      phase     = esc_phase;
      esc_phase = PHASE_IDLE;
      case (phase)
         PHASE_PERCENT: begin
            if (!escape_like(c)) begin
               // The percent sign is dropped; the byte is decoded afresh.
               decode_plain(c, l);
            end else if (l) begin
               expect_beat(c, 1'b1);
            end else begin
               esc_lead  = c;
               esc_phase = PHASE_DIGIT;
            end
         end
         PHASE_DIGIT: begin
            if (escape_like(c)) begin
               // Parsing stops at the first non-hex character, as a base-16 parse does.
               hi = digit_value(esc_lead);
               lo = digit_value(c);
               if (hi < 0) expect_beat(8'h00, l);
               else if (lo < 0) expect_beat(8'(hi), l);
               else expect_beat(8'(hi * 16 + lo), l);
            end else begin
               expect_beat(esc_lead, 1'b0);
               decode_plain(c, l);
            end
         end
         default: decode_plain(c, l);
      endcase
      if (l) esc_phase = PHASE_IDLE;
   endfunction

   function automatic void row_checked(input logic [ByteWidth-1:0] b, input logic l);
      stim_row_type row;
      row       = '0;
      row.data  = b;
      row.last  = l;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void row_typed(input logic [ByteWidth-1:0] b, input logic l,
                                     input logic [1:0] n,
                                     input logic [ByteWidth-1:0] b0, input logic l0,
                                     input logic [ByteWidth-1:0] b1, input logic l1);
      stim_row_type row;
      row                   = '0;
      row.data              = b;
      row.last              = l;
      row.typed             = 1'b1;
      row.want.count        = n;
      row.want.first.data   = b0;
      row.want.first.last   = l0;
      row.want.second.data  = b1;
      row.want.second.last  = l1;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Fills text_q with one random encoded string: mostly well-formed escapes, plain bytes
   // and plus signs, with some broken escapes and an occasional truncated tail.
   task automatic build_string();
      int pieces, k, pick;
      text_q.delete();
      pieces = $urandom_range(1, 6);
      for (k = 0; k < pieces; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            text_q.insert(text_q.size(), 8'($urandom_range(1, 255)));
         end else if (pick < 40) begin
            text_q.insert(text_q.size(), CHAR_PLUS);
         end else if (pick < 75) begin
            text_q.insert(text_q.size(), CHAR_PERCENT);
            text_q.insert(text_q.size(), hex_char($urandom_range(0, 15)));
            text_q.insert(text_q.size(), hex_char($urandom_range(0, 15)));
         end else if (pick < 90) begin
            // Any escape characters, the non-hex 0x3A..0x3F among them.
            text_q.insert(text_q.size(), CHAR_PERCENT);
            repeat (2) begin
               pick = $urandom_range(0, 21);
               text_q.insert(text_q.size(),
                             (pick < 16) ? 8'(8'h30 + pick) : 8'(8'h41 + pick - 16));
            end
         end else begin
            text_q.insert(text_q.size(), CHAR_PERCENT);
            text_q.insert(text_q.size(), 8'($urandom_range(1, 255)));
         end
      end
      if (text_q.size() > 1 && $urandom_range(0, 5) == 0) void'(text_q.pop_back());
   endtask

   // Presents one beat on the request side and returns at the falling edge after it was
   // taken. The sender runs in bursts with random gaps between them.
   task automatic send_row(input stim_row_type row);
      int gap, seen;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
         gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      seen        = bytes_taken;
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.last;
      cur_row    <= row;
      do @(negedge clock); while (bytes_taken == seen);
   endtask

   // Both channels are sampled at the rising edge. An accepted request beat feeds the
   // decoder; an accepted response beat is checked against the oldest expectation.
   always @(posedge clock) begin
      int            queued;
      logic          moved;
      upd_entry_type want;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            queued = decoded_q.size();
            decode_byte(req_tdata, req_tlast);
            if (cur_row.typed) begin
               // Keep the decoder state, but hold the block to the beats in the table.
               while (decoded_q.size() > queued) void'(decoded_q.pop_back());
               if (cur_row.want.count > 0)
                  decoded_q.insert(decoded_q.size(), cur_row.want.first);
               if (cur_row.want.count > 1)
                  decoded_q.insert(decoded_q.size(), cur_row.want.second);
            end
            bytes_taken++;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat data %02h last %0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("data %02h, wanted %02h", rsp_tdata, want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %0b on data %02h, wanted %0b",
                                            rsp_tlast, rsp_tdata, want.last));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // The receiver switches between free running, light stalls and heavy stalls.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left  = $urandom_range(8, 120);
         ready_mode = ready_mode_type'($urandom_range(0, 2));
      end
      mode_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_OFTEN:  rsp_tready <= ($urandom_range(0, 3) != 0);
         default:      rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: a long stretch with no beat moving on either side ends the run.
   initial begin
      wait (idle_cycles >= IdleLimit);
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      int           i, sent;
      stim_row_type row;

      // Extremes of the byte range, the plus sign and a percent sign at the very end.
      row_typed(8'h01, 1'b0, 2'd1, 8'h01, 1'b0, 8'h00, 1'b0);
      row_typed(8'hFF, 1'b0, 2'd1, 8'hFF, 1'b0, 8'h00, 1'b0);
      row_typed(CHAR_PLUS, 1'b1, 2'd1, CHAR_SPACE, 1'b1, 8'h00, 1'b0);
      row_typed(CHAR_PERCENT, 1'b1, 2'd1, CHAR_PERCENT, 1'b1, 8'h00, 1'b0);
      // Well-formed escapes: %41 and %FF, the latter closing the string.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_checked(8'h34, 1'b0);
      row_checked(8'h31, 1'b1);
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_checked(8'h46, 1'b0);
      row_checked(8'h46, 1'b1);
      // Lowercase is not an escape character: the percent sign disappears.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h61, 1'b1, 2'd1, 8'h61, 1'b1, 8'h00, 1'b0);
      // A second percent sign in place of the first escape character opens a new escape,
      // which a plus sign then breaks.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(CHAR_PLUS, 1'b1, 2'd1, CHAR_SPACE, 1'b1, 8'h00, 1'b0);
      // Non-hex escape characters: a leading one gives zero, a trailing one the lead digit.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h3A, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_checked(8'h35, 1'b0);
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h37, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_checked(8'h3F, 1'b0);
      // A bad second character releases the held one as well: two beats from one byte.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h33, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h67, 1'b1, 2'd2, 8'h33, 1'b0, 8'h67, 1'b1);
      // An escape cut short by the end of the string.
      row_typed(CHAR_PERCENT, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      row_typed(8'h42, 1'b1, 2'd1, 8'h42, 1'b1, 8'h00, 1'b0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) send_row(directed_rows[i]);

      sent = 0;
      while (sent < RandomItems) begin
         build_string();
         for (i = 0; i < text_q.size(); i++) begin
            row      = '0;
            row.data = text_q[i];
            row.last = (i == text_q.size() - 1);
            send_row(row);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (decoded_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[sim.f]
src/upd_pkg.sv
src/upd_decode.sv
src/upd_out_queue.sv
src/url_percent_decoder_core.sv
tb/tb_top.sv
